// File: hdl/bsll_pkg.sv
// ----------------------------------------------------------------------------
// Bounded list engine package
// Shared sizes, operation and status codes, state encoding and the command
// and status structs used between the engine and its slot map.
// ----------------------------------------------------------------------------
package bsll_pkg;

   localparam int LIST_CAPACITY = 16;
   localparam int SLOT_W        = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
   localparam int CNT_W         = $clog2(LIST_CAPACITY + 1);
   localparam int KIND_W        = 3;
   localparam int STATUS_W      = 2;
   localparam int ELEM_W        = 32;

   typedef enum logic [KIND_W-1:0] {
      KIND_INS_END  = 3'd0,
      KIND_INS_HEAD = 3'd1,
      KIND_DEL_VAL  = 3'd2,
      KIND_DEL_HEAD = 3'd3,
      KIND_DEL_TAIL = 3'd4,
      KIND_LIST     = 3'd5
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_DISPATCH = 6'b000010,
      S_INS_LINK = 6'b000100,
      S_HEAD_RD  = 6'b001000,
      S_WALK     = 6'b010000,
      S_EMIT     = 6'b100000
   } state_type;

   typedef struct packed {
      logic              alloc_en;
      logic              free_en;
      logic [SLOT_W-1:0] free_slot;
   } map_cmd_type;

   typedef struct packed {
      logic                     any_free;
      logic [SLOT_W-1:0]        low_free;
      logic [LIST_CAPACITY-1:0] in_use;
   } map_stat_type;

endpackage

// File: hdl/bsll_ifs.sv
// ----------------------------------------------------------------------------
// Bounded list engine channels
// Valid/ready channels for operation words and result words.
// ----------------------------------------------------------------------------
interface bsll_req_if;
   logic                                valid;
   logic                                ready;
   logic [bsll_pkg::KIND_W-1:0]         kind;
   logic signed [bsll_pkg::ELEM_W-1:0]  value;

   modport source (output valid, output kind, output value, input ready);
   modport sink   (input valid, input kind, input value, output ready);
endinterface

interface bsll_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [bsll_pkg::STATUS_W-1:0]       status;
   logic signed [bsll_pkg::ELEM_W-1:0]  element;
   logic                                last;

   modport source (output valid, output status, output element, output last, input ready);
   modport sink   (input valid, input status, input element, input last, output ready);
endinterface

// File: hdl/bsll_slot_map.sv
// ----------------------------------------------------------------------------
// Slot occupancy map
// One bit per slot; reports the lowest free slot and takes one allocate and
// one release per cycle.
// ----------------------------------------------------------------------------
module bsll_slot_map (
   input  logic                   clock,
   input  logic                   reset,
   input  bsll_pkg::map_cmd_type  cmd,
   output bsll_pkg::map_stat_type stat
);

   logic [bsll_pkg::LIST_CAPACITY-1:0] used_ff;
   logic [bsll_pkg::LIST_CAPACITY-1:0] used_in;
   logic [bsll_pkg::SLOT_W-1:0]        low_free;

   // Priority encode from the top down so the lowest free slot wins.
   always_comb begin
      low_free = '0;
      for (int i = bsll_pkg::LIST_CAPACITY - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            low_free = bsll_pkg::SLOT_W'(i);
         end
      end
   end

   always_comb begin
      used_in = used_ff;
      if (cmd.alloc_en) begin
         used_in[low_free] = 1'b1;
      end
      if (cmd.free_en) begin
         used_in[cmd.free_slot] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   assign stat.any_free = ~&used_ff;
   assign stat.low_free = low_free;
   assign stat.in_use   = used_ff;

endmodule

// File: hdl/bounded_singly_linked_list.sv
// ----------------------------------------------------------------------------
// Bounded singly linked list engine
// Fixed-capacity list kept in a value memory and a successor-link memory.
// ----------------------------------------------------------------------------
// Each word on req_ch is one operation (kind, value): insert at end, insert
// at head, delete the first node equal to value, delete head, delete tail, or
// list the contents. Kinds six and seven are dropped with no result word.
// Every other operation gives one result word on rsp_ch with last set, except
// a listing, which gives one word per element from head to tail, the final
// one flagged with last; an empty list gives one word with status empty.
// The engine handles one operation at a time. Inserts, delete head and any
// operation on an empty list go from dispatch (via the link step or head
// read where needed) to the emit state and then back to idle, where the next
// operation is taken. Delete by value, delete tail and listing follow the
// successor links with one read of the link memory per cycle; a listing
// reads on only while the output register is free to take its word.
// Results go through an output register, so a new operation is accepted
// while the last result word still waits for the receiver. When rsp_ch
// stalls, the engine holds its walk and the output word until it is taken.
// Reset clears the occupancy map, head, tail and count, giving an empty
// list at once; the memories themselves are not cleared.
// ----------------------------------------------------------------------------
module bounded_singly_linked_list (
   input  logic       clock,
   input  logic       reset,
   bsll_req_if.sink   req_ch,
   bsll_rsp_if.source rsp_ch
);

   localparam int SW = bsll_pkg::SLOT_W;
   localparam int CW = bsll_pkg::CNT_W;
   localparam int EW = bsll_pkg::ELEM_W;

   // Memories and their registered read ports.
   logic signed [EW-1:0] val_mem  [bsll_pkg::LIST_CAPACITY];
   logic [SW-1:0]        link_mem [bsll_pkg::LIST_CAPACITY];
   logic signed [EW-1:0] val_q;
   logic [SW-1:0]        link_q;
   logic                 rd_en;
   logic [SW-1:0]        rd_addr;
   logic                 val_we;
   logic [SW-1:0]        val_waddr;
   logic signed [EW-1:0] val_wdata;
   logic                 link_we;
   logic [SW-1:0]        link_waddr;
   logic [SW-1:0]        link_wdata;

   // Control and list registers.
   bsll_pkg::state_type  state_ff, state_in;
   logic [bsll_pkg::KIND_W-1:0] op_kind_ff, op_kind_in;
   logic signed [EW-1:0] op_value_ff, op_value_in;
   logic [SW-1:0]        head_ff, head_in;
   logic [SW-1:0]        tail_ff, tail_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [SW-1:0]        cur_ff, cur_in;
   logic [SW-1:0]        prev_ff, prev_in;
   logic [CW-1:0]        n_ff, n_in;
   bsll_pkg::status_type res_status_ff, res_status_in;
   logic signed [EW-1:0] res_element_ff, res_element_in;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   bsll_pkg::status_type rsp_status_ff, rsp_status_in;
   logic signed [EW-1:0] rsp_element_ff, rsp_element_in;
   logic                 rsp_last_ff, rsp_last_in;

   bsll_pkg::map_cmd_type  map_cmd;
   bsll_pkg::map_stat_type map_stat;

   logic out_free;
   logic at_last;
   logic list_full;
   logic release_cur;

   bsll_slot_map u_slot_map (
      .clock (clock),
      .reset (reset),
      .cmd   (map_cmd),
      .stat  (map_stat)
   );

   // Accesses never overlap: every write completes before the engine returns
   // to idle, and the next read is issued no earlier than the cycle after.
   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[val_waddr] <= val_wdata;
      end
      if (rd_en) begin
         val_q <= val_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      if (rd_en) begin
         link_q <= link_mem[rd_addr];
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign at_last   = (n_ff + CW'(1)) == cnt_ff;
   assign list_full = (cnt_ff >= CW'(bsll_pkg::LIST_CAPACITY)) || !map_stat.any_free;

   always_comb begin
      state_in       = state_ff;
      op_kind_in     = op_kind_ff;
      op_value_in    = op_value_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      cnt_in         = cnt_ff;
      cur_in         = cur_ff;
      prev_in        = prev_ff;
      n_in           = n_ff;
      res_status_in  = res_status_ff;
      res_element_in = res_element_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_element_in = rsp_element_ff;
      rsp_last_in    = rsp_last_ff;
      rd_en          = 1'b0;
      rd_addr        = head_ff;
      val_we         = 1'b0;
      val_waddr      = map_stat.low_free;
      val_wdata      = op_value_ff;
      link_we        = 1'b0;
      link_waddr     = map_stat.low_free;
      link_wdata     = '0;
      map_cmd        = '0;
      release_cur    = 1'b0;

      case (state_ff)
         bsll_pkg::S_IDLE: begin
            if (req_ch.valid) begin
               op_kind_in  = req_ch.kind;
               op_value_in = req_ch.value;
               state_in    = bsll_pkg::S_DISPATCH;
            end
         end

         bsll_pkg::S_DISPATCH: begin
            cur_in         = head_ff;
            prev_in        = head_ff;
            n_in           = '0;
            res_status_in  = bsll_pkg::ST_OK;
            res_element_in = '0;
            case (bsll_pkg::kind_type'(op_kind_ff))
               bsll_pkg::KIND_INS_END, bsll_pkg::KIND_INS_HEAD: begin
                  state_in = bsll_pkg::S_EMIT;
                  if (list_full) begin
                     res_status_in = bsll_pkg::ST_FULL;
                  end else begin
                     val_we           = 1'b1;
                     link_we          = 1'b1;
                     map_cmd.alloc_en = 1'b1;
                     cnt_in           = cnt_ff + CW'(1);
                     if (cnt_ff == '0) begin
                        head_in = map_stat.low_free;
                        tail_in = map_stat.low_free;
                     end else if (op_kind_ff == bsll_pkg::KIND_INS_HEAD) begin
                        link_wdata = head_ff;
                        head_in    = map_stat.low_free;
                     end else begin
                        // The old tail still has to point at the new node.
                        prev_in  = tail_ff;
                        cur_in   = map_stat.low_free;
                        tail_in  = map_stat.low_free;
                        state_in = bsll_pkg::S_INS_LINK;
                     end
                  end
               end
               bsll_pkg::KIND_DEL_VAL, bsll_pkg::KIND_DEL_HEAD,
               bsll_pkg::KIND_DEL_TAIL, bsll_pkg::KIND_LIST: begin
                  if (cnt_ff == '0) begin
                     res_status_in = bsll_pkg::ST_EMPTY;
                     state_in      = bsll_pkg::S_EMIT;
                  end else begin
                     rd_en   = 1'b1;
                     rd_addr = head_ff;
                     if (op_kind_ff == bsll_pkg::KIND_DEL_HEAD) begin
                        state_in = bsll_pkg::S_HEAD_RD;
                     end else begin
                        state_in = bsll_pkg::S_WALK;
                     end
                  end
               end
               default: begin
                  state_in = bsll_pkg::S_IDLE;
               end
            endcase
         end

         bsll_pkg::S_INS_LINK: begin
            link_we    = 1'b1;
            link_waddr = prev_ff;
            link_wdata = cur_ff;
            state_in   = bsll_pkg::S_EMIT;
         end

         bsll_pkg::S_HEAD_RD: begin
            res_element_in = val_q;
            head_in        = link_q;
            release_cur    = 1'b1;
            state_in       = bsll_pkg::S_EMIT;
         end

         bsll_pkg::S_WALK: begin
            case (bsll_pkg::kind_type'(op_kind_ff))
               bsll_pkg::KIND_LIST: begin
                  if (out_free) begin
                     rsp_valid_in   = 1'b1;
                     rsp_status_in  = bsll_pkg::ST_OK;
                     rsp_element_in = val_q;
                     rsp_last_in    = at_last;
                     if (at_last) begin
                        state_in = bsll_pkg::S_IDLE;
                     end else begin
                        cur_in  = link_q;
                        n_in    = n_ff + CW'(1);
                        rd_en   = 1'b1;
                        rd_addr = link_q;
                     end
                  end
               end
               bsll_pkg::KIND_DEL_VAL: begin
                  if (val_q == op_value_ff) begin
                     if (n_ff == '0) begin
                        head_in = link_q;
                     end else begin
                        link_we    = 1'b1;
                        link_waddr = prev_ff;
                        link_wdata = link_q;
                        if (cur_ff == tail_ff) begin
                           tail_in = prev_ff;
                        end
                     end
                     release_cur    = 1'b1;
                     res_element_in = op_value_ff;
                     state_in       = bsll_pkg::S_EMIT;
                  end else if (at_last) begin
                     res_status_in = bsll_pkg::ST_NOT_FOUND;
                     state_in      = bsll_pkg::S_EMIT;
                  end else begin
                     prev_in = cur_ff;
                     cur_in  = link_q;
                     n_in    = n_ff + CW'(1);
                     rd_en   = 1'b1;
                     rd_addr = link_q;
                  end
               end
               bsll_pkg::KIND_DEL_TAIL: begin
                  if (at_last) begin
                     res_element_in = val_q;
                     if (cnt_ff > CW'(1)) begin
                        tail_in = prev_ff;
                     end
                     release_cur = 1'b1;
                     state_in    = bsll_pkg::S_EMIT;
                  end else begin
                     prev_in = cur_ff;
                     cur_in  = link_q;
                     n_in    = n_ff + CW'(1);
                     rd_en   = 1'b1;
                     rd_addr = link_q;
                  end
               end
               default: begin
                  state_in = bsll_pkg::S_IDLE;
               end
            endcase
         end

         bsll_pkg::S_EMIT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_element_in = res_element_ff;
               rsp_last_in    = 1'b1;
               state_in       = bsll_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = bsll_pkg::S_IDLE;
         end
      endcase

      // Releasing the current node; an emptied list parks head and tail at zero.
      if (release_cur) begin
         map_cmd.free_en   = 1'b1;
         map_cmd.free_slot = cur_ff;
         cnt_in            = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            head_in = '0;
            tail_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsll_pkg::S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_kind_ff     <= op_kind_in;
      op_value_ff    <= op_value_in;
      cur_ff         <= cur_in;
      prev_ff        <= prev_in;
      n_ff           <= n_in;
      res_status_ff  <= res_status_in;
      res_element_ff <= res_element_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_element_ff <= rsp_element_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign req_ch.ready   = (state_ff == bsll_pkg::S_IDLE);
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.status  = rsp_status_ff;
   assign rsp_ch.element = rsp_element_ff;
   assign rsp_ch.last    = rsp_last_ff;

   // The occupancy map and the element count must always agree.
   a_map_matches_count: assert property (@(posedge clock) disable iff (reset)
      $countones(map_stat.in_use) == 32'(cnt_ff))
      else $error("slot map population differs from entry count");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(bsll_pkg::LIST_CAPACITY))
      else $error("entry count above capacity");

   a_count_steps: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (cnt_ff == $past(cnt_ff)) ||
                        (cnt_ff == $past(cnt_ff) + CW'(1)) ||
                        (cnt_ff == $past(cnt_ff) - CW'(1)))
      else $error("entry count moved by more than one");

   a_empty_parks_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bsll_pkg::S_IDLE) && (cnt_ff == '0) |->
         (head_ff == '0) && (tail_ff == '0))
      else $error("empty list with head or tail not at slot zero");

endmodule
